/* design/pctd_pkg.sv */
// Shared types, character codes and hex helpers for the percent decoder.
package pctd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Escape phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // One accepted byte turns into up to three decoded bytes.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            last;
  } pctd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pctd_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Valid only for hex digits: '0'-'9' keep the low nibble, letters add 9.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    if (c <= 8'h39) begin
      n = c[3:0];
    end else begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

/* design/pctd_chan_if.sv */
// Valid/ready channel interfaces for encoded input bytes and decoded output bytes.
interface pctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface pctd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* design/pctd_front.sv */
// Front end: accepts encoded bytes, tracks the escape phase, builds output commands.
module pctd_front (
  input  logic                clk,
  input  logic                rst_n,
  pctd_in_if.sink             in_ch,
  input  pctd_pkg::pctd_qstat_t qstat,
  output logic                push,
  output pctd_pkg::pctd_cmd_t cmd
);
  import pctd_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       v_ok, h_ok;
  logic       idle_to_pct, idle_emit;
  logic [7:0] idle_byte;
  logic       use_idle;
  logic [1:0] pre;

  assign in_ch.ready = ~qstat.full;
  assign accept      = in_ch.valid & in_ch.ready;

  assign v_ok = is_hex(in_ch.in_byte);
  assign h_ok = is_hex(held_r);

  // Handling of the byte as if idle
  assign idle_to_pct = (in_ch.in_byte == PCT_CHAR) & ~in_ch.is_last;
  assign idle_emit   = ~idle_to_pct;
  assign idle_byte   = (in_ch.in_byte == PLUS_CHAR) ? SPACE_CHAR : in_ch.in_byte;

  always_comb begin
    cmd       = '0;
    cmd.last  = in_ch.is_last;
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    use_idle  = 1'b1;
    pre       = 2'd0;
    case (phase_r)
      PH_PCT: begin
        if (v_ok && !in_ch.is_last) begin
          use_idle  = 1'b0;
          phase_nxt = PH_DIGIT;
          held_nxt  = in_ch.in_byte;
        end else begin
          cmd.data[0] = PCT_CHAR;
          pre         = 2'd1;
        end
      end
      PH_DIGIT: begin
        held_nxt = '0;
        if (v_ok && h_ok) begin
          use_idle    = 1'b0;
          cmd.data[0] = {nibble_of(held_r), nibble_of(in_ch.in_byte)};
          cmd.cnt     = 2'd1;
        end else begin
          cmd.data[0] = PCT_CHAR;
          cmd.data[1] = held_r;
          pre         = 2'd2;
        end
      end
      default: ;
    endcase
    if (use_idle) begin
      cmd.cnt = pre + {1'b0, idle_emit};
      if (idle_emit) begin
        cmd.data[pre] = idle_byte;
      end
      if (idle_to_pct) begin
        phase_nxt = PH_PCT;
      end
    end
  end

  assign push = accept & (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* design/pctd_queue.sv */
// Short command queue between the front end and the output sequencer.
module pctd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pctd_pkg::pctd_cmd_t   wr_cmd,
  input  logic                  pop,
  output pctd_pkg::pctd_cmd_t   head,
  output pctd_pkg::pctd_qstat_t qstat
);
  import pctd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pctd_cmd_t        slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign head        = slots_r[rd_ptr_r];
  assign qstat.full  = (count_r == FULL_CNT);
  assign qstat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/pctd_back.sv */
// Back end: walks each queued command one byte at a time into the output register.
module pctd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pctd_pkg::pctd_cmd_t   head,
  input  pctd_pkg::pctd_qstat_t qstat,
  output logic                  pop,
  pctd_out_if.source            out_ch
);
  import pctd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load, final_b;

  assign load    = ~out_valid_r | out_ch.ready;
  assign final_b = (idx_r == head.cnt - 2'd1);
  assign pop     = load & ~qstat.empty & final_b;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = ~qstat.empty;
      if (!qstat.empty) begin
        out_byte_nxt = head.data[idx_r];
        out_last_nxt = head.last & final_b;
        idx_nxt      = final_b ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

endmodule

/* design/percent_decoder_unit.sv */
// Top level of the streaming URL percent decoder.
// Decodes a URL-encoded byte stream: '%' plus two hex digits (either case) becomes one
// byte, '+' becomes a space, anything else passes through. A broken or cut-off escape
// emits a literal '%' and any pending digit, then handles the byte itself as if idle;
// is_last flushes anything pending and marks the final decoded byte with out_last.
// The input takes one transaction per cycle while the command queue has room. An input
// byte yields zero to three output transactions, and the output register sends one per
// cycle while out_ch.ready is high, so sustained throughput is one input per cycle for
// ordinary text; each extra byte of a broken escape is one more output transaction. The
// front end and the output sequencer are decoupled by a QUEUE_DEPTH-entry command queue;
// in_ch.ready drops only when that queue is full. The command of an accepted input goes
// into the queue, and out_ch.valid rises once the output register loads it from the head.
module percent_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  pctd_in_if.sink     in_ch,
  pctd_out_if.source  out_ch
);
  import pctd_pkg::*;

  pctd_cmd_t   push_cmd;   // command built from the current input transaction
  pctd_cmd_t   head_cmd;   // oldest command waiting for the output sequencer
  pctd_qstat_t qstat;
  logic        push;
  logic        pop;

  // Classify each byte, advance the escape phase, emit a command of 1..3 bytes
  pctd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .cmd   (push_cmd)
  );

  // Hold commands so the input keeps flowing while the output is stalled
  pctd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .head   (head_cmd),
    .qstat  (qstat)
  );

  // Drain each command byte by byte through the output register
  pctd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_cmd),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* design/pctd_checker.sv */
// Port-level checker for the percent decoder, bound to the top level.
module pctd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A full queue implies the output register is busy
  a_backpressure_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while output idle");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

endmodule

bind percent_decoder_unit pctd_checker u_pctd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);

/* tb/tb.sv */
// Self-checking testbench for the percent decoder: directed and random traffic with a scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pctd_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int HOLD_CYCLES     = 80;

  // Digit bounds for the hex check
  localparam logic [7:0] CH_0  = "0";
  localparam logic [7:0] CH_9  = "9";
  localparam logic [7:0] CH_UA = "A";
  localparam logic [7:0] CH_UF = "F";
  localparam logic [7:0] CH_LA = "a";
  localparam logic [7:0] CH_LF = "f";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic clk;
  logic rst_n;

  pctd_in_if  in_ch();
  pctd_out_if out_ch();

  percent_decoder_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Decoder state mirror and the queue of decoded bytes still to come out.
  logic [1:0] dec_phase = PH_IDLE;
  logic [7:0] dec_held  = '0;
  dec_byte_t  expected_bytes[$];

  int error_count    = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int unsigned cycle_count = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run as a failure once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("FAIL percent_decoder_unit");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Decode prediction
  // ---------------------------------------------------------------------------

  // Nibble value of a hex digit character, -1 for anything else.
  function automatic int hex_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  function automatic void expect_byte(input logic [7:0] d, input logic last);
    dec_byte_t e;
    e.data = d;
    e.last = last;
    expected_bytes.push_back(e);
  endfunction

  // Handle one character as if no escape were pending.
  function automatic void decode_idle(input logic [7:0] b, input logic last);
    if (b == PCT_CHAR) begin
      // A lone '%' at the end of the string goes out as itself.
      if (last) begin
        expect_byte(PCT_CHAR, 1'b1);
        dec_phase = PH_IDLE;
      end else begin
        dec_phase = PH_PCT;
      end
    end else if (b == PLUS_CHAR) begin
      expect_byte(SPACE_CHAR, last);
      dec_phase = PH_IDLE;
    end else begin
      expect_byte(b, last);
      dec_phase = PH_IDLE;
    end
  endfunction

  // Advance the mirror by one accepted character and queue what it yields.
  function automatic void decode_step(input logic [7:0] b, input logic last);
    int lo;
    int hi;
    lo = hex_value(b);
    case (dec_phase)
      PH_PCT: begin
        if (lo >= 0 && !last) begin
          dec_held  = b;
          dec_phase = PH_DIGIT;
        end else begin
          // Broken or cut off right after '%': literal '%', then redo the byte.
          expect_byte(PCT_CHAR, 1'b0);
          dec_phase = PH_IDLE;
          decode_idle(b, last);
        end
      end
      PH_DIGIT: begin
        hi = hex_value(dec_held);
        if (lo >= 0 && hi >= 0) begin
          // Complete escape, also when the second digit ends the string.
          expect_byte({hi[3:0], lo[3:0]}, last);
          dec_phase = PH_IDLE;
        end else begin
          expect_byte(PCT_CHAR, 1'b0);
          expect_byte(dec_held, 1'b0);
          dec_phase = PH_IDLE;
          decode_idle(b, last);
        end
        dec_held = '0;
      end
      default: begin
        // Unused phase code counts as idle.
        dec_phase = PH_IDLE;
        decode_idle(b, last);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready generation and result checking
  // ---------------------------------------------------------------------------

  // Random stalls, plus a long hold-off whenever a test asks for one.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare every output transaction with the oldest queued byte.
  always @(posedge clk) begin : check_output
    dec_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                  out_ch.out_byte, out_ch.out_last));
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.out_last !== want.last) begin
          report_mismatch($sformatf("output byte %02h last %0b, wanted %02h last %0b",
                                    out_ch.out_byte, out_ch.out_last, want.data, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one character; idle cycles come first and carry junk payload.
  // Valid stays high across back-to-back transactions.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      in_ch.is_last <= 1'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_step(b, last);
    items_sent++;
  endtask

  // Send a text literal; flag the final character when end_flag is set.
  task automatic send_text(input string s, input logic end_flag);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], end_flag && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_hex();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(21)];
  endfunction

  // Non-hex character, half the time one that sits right next to a digit range.
  function automatic logic [7:0] pick_non_hex();
    logic [7:0] near[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    logic [7:0] c;
    if ($urandom_range(1)) return near[$urandom_range(5)];
    do c = 8'($urandom); while (hex_value(c) >= 0);
    return c;
  endfunction

  // Build one mostly well-formed string and send it with last on its end.
  task automatic send_random_string();
    logic [7:0] s[$];
    int n_seg;
    int pick;
    n_seg = $urandom_range(1, 5);
    for (int i = 0; i < n_seg; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        s.push_back(PCT_CHAR);
        s.push_back(pick_hex());
        s.push_back(pick_hex());
      end else if (pick < 48) begin
        s.push_back(PCT_CHAR);
        s.push_back(pick_non_hex());
      end else if (pick < 56) begin
        s.push_back(PCT_CHAR);
        s.push_back(pick_hex());
        s.push_back(pick_non_hex());
      end else if (pick < 62) begin
        // Half an escape: cut off if it ends the string
        s.push_back(PCT_CHAR);
        s.push_back(pick_hex());
      end else if (pick < 67) begin
        s.push_back(PCT_CHAR);
      end else if (pick < 77) begin
        s.push_back(PLUS_CHAR);
      end else begin
        s.push_back(8'($urandom));
      end
    end
    for (int i = 0; i < s.size(); i++) begin
      send_byte(s[i], i == s.size() - 1);
    end
  endtask

  // Raw bytes with random last flags.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(8'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("+", 1'b0);
    send_text("+", 1'b1);
  endtask

  task automatic test_escapes();
    send_text("%41", 1'b0);
    // Escape whose second digit ends the string
    send_text("%fF", 1'b1);
  endtask

  task automatic test_broken_escapes();
    // Non-hex right after '%'
    send_text("%z", 1'b0);
    // Non-hex after one digit, then a lone '%' at the end
    send_text("%3%%", 1'b1);
    send_text("%+", 1'b0);
  endtask

  task automatic test_cut_off();
    send_text("%A", 1'b1);
    send_text("%", 1'b1);
    send_text("%9q", 1'b1);
  endtask

  // Four idling mixes, mostly well-formed strings with some raw noise.
  task automatic test_random_traffic();
    int send_mix[4] = '{0, 51, 0, 34};
    int recv_mix[4] = '{0, 0, 51, 34};
    int start;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 15) begin
          send_noise();
        end else begin
          send_random_string();
        end
      end
    end
  endtask

  // Hold the output off for a long stretch while the input keeps offering
  // broken escapes, so the command queue fills and input ready drops.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (7) send_text("%5G", 1'b0);
    send_text("%5G", 1'b1);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.is_last = 1'b0;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_bytes();
    test_escapes();
    test_broken_escapes();
    test_cut_off();
    test_random_traffic();
    test_output_backpressure();

    // Stop offering, let the output run free and drain.
    in_ch.valid    <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS percent_decoder_unit");
    end else begin
      $display("FAIL percent_decoder_unit");
    end
    $finish;
  end

endmodule
